>>> hdl/cht_pkg.sv
// shared types, codes and default sizes for the chained hash key-value table
package cht_pkg;

	localparam int FIELD_W = 32;

	localparam int BUCKETS_DEF    = 16;
	localparam int WAYS_DEF       = 4;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;

	typedef logic [1:0] action_t;
	typedef logic [1:0] status_t;

	localparam action_t ACT_SEARCH = 2'd0;
	localparam action_t ACT_INSERT = 2'd1;
	localparam action_t ACT_DELETE = 2'd2;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_DUP      = 2'd1;
	localparam status_t ST_NOTFOUND = 2'd2;
	localparam status_t ST_FULL     = 2'd3;

endpackage

>>> hdl/cht_ram.sv
// generic simple dual-port ram with registered read
module cht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/cht_hash.sv
// bucket hash: key modulo bucket count, a mask for powers of two, else a reciprocal multiply
module cht_hash #(
	parameter int BUCKETS = 16,
	parameter int KW      = 32,
	parameter int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [KW-1:0] key,
	output logic          done,
	output logic [BW-1:0] bucket
);

	localparam bit POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
	localparam int SH   = (BW > 1) ? BW - 1 : 0;
	// quotient magic number, below 2**KW for any divisor
	localparam longint unsigned MAGIC_L =
		((64'd1 << (KW + BW)) / 64'(BUCKETS)) - (64'd1 << KW) + 64'd1;
	localparam logic [KW-1:0] MAGIC = KW'(MAGIC_L);

	logic            run1_q;
	logic            run2_q;
	logic            done_q;
	logic [KW-1:0]   key_q;
	logic [KW-1:0]   t_q;
	logic [BW-1:0]   rem_q;
	logic [2*KW-1:0] prod;
	logic [KW-1:0]   q_est;
	logic [BW-1:0]   qb;
	logic [BW-1:0]   key_low;

	// quotient from the high product half, remainder only needs the low bits
	always_comb begin
		prod    = (2 * KW)'(MAGIC) * (2 * KW)'(key_q);
		q_est   = (t_q + ((key_q - t_q) >> 1)) >> SH;
		qb      = BW'(q_est) * BW'(BUCKETS);
		key_low = BW'((BW + KW)'(key) & (BW + KW)'(BUCKETS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run1_q <= 1'b0;
			run2_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			run1_q <= start && !POW2;
			run2_q <= run1_q;
			done_q <= (start && POW2) || run2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
		end
		if (run1_q) begin
			t_q <= prod[2*KW-1:KW];
		end
		if (start && POW2) begin
			rem_q <= key_low;
		end else if (run2_q) begin
			rem_q <= BW'(key_q) - qb;
		end
	end

	assign done   = done_q;
	assign bucket = rem_q;

endmodule

>>> hdl/chained_hash_key_value_table_unit.sv
// Hash table of BUCKETS buckets with WAYS slots each; keys and values live in one
// entry ram, the per-bucket valid words in a second ram. After reset a clearing
// pass zeroes the valid ram, one bucket per cycle, during which no item is taken.
// Items are handled one at a time: the bucket (key modulo BUCKETS) and its base
// address come from the hash unit, by a mask when BUCKETS is a power of two, else
// by a reciprocal multiply over two steps; the ways are then read from the entry
// ram one per cycle, and a final state writes back and loads the result register
// once that register is free.
// The result register frees the output side: a waiting result does not hold up
// the next item until that item reaches its own final cycle.
module chained_hash_key_value_table_unit #(
	parameter int BUCKETS    = cht_pkg::BUCKETS_DEF,
	parameter int WAYS       = cht_pkg::WAYS_DEF,
	parameter int KEY_BITS   = cht_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = cht_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  cht_pkg::action_t              action,
	input  logic [cht_pkg::FIELD_W-1:0]   key,
	input  logic [cht_pkg::FIELD_W-1:0]   value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output cht_pkg::status_t              status,
	output logic [cht_pkg::FIELD_W-1:0]   result_value
);

	import cht_pkg::*;

	localparam int KW    = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
	localparam int VW    = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
	localparam int EW    = KW + VW;
	localparam int SLOTS = BUCKETS * WAYS;
	localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WCW   = $clog2(WAYS + 1);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_HASH = 3'd2;
	localparam logic [2:0] S_WALK = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]     state_q;
	logic [BW-1:0]  clr_q;
	action_t        act_q;
	logic [KW-1:0]  key_q;
	logic [VW-1:0]  value_q;
	logic [BW-1:0]  bucket_q;
	logic [AW-1:0]  base_q;
	logic [WCW-1:0] rd_way_q;
	logic           rd_s1;
	logic [WW-1:0]  way_s1;
	logic           hit_q;
	logic [WW-1:0]  hit_way_q;
	logic [VW-1:0]  hit_val_q;
	logic           free_found_q;
	logic [WW-1:0]  free_way_q;
	logic [WAYS-1:0] vword_q;
	logic           out_valid_q;
	status_t        status_q;
	logic [VW-1:0]  rv_q;

	logic           accept;
	logic           hash_done;
	logic [BW-1:0]  hash_bucket;
	logic           fin_go;
	status_t        fin_status;
	logic [VW-1:0]  fin_rv;
	logic           ins_ok;
	logic           del_ok;

	logic           vram_we;
	logic [BW-1:0]  vram_waddr;
	logic [WAYS-1:0] vram_wdata;
	logic           vram_re;
	logic [WAYS-1:0] vram_rdata;

	logic           ent_we;
	logic [AW-1:0]  ent_waddr;
	logic           ent_re;
	logic [AW-1:0]  ent_raddr;
	logic [EW-1:0]  ent_rdata;
	logic [KW-1:0]  rd_key;
	logic [VW-1:0]  rd_val;
	logic           way_live;
	logic           way_hit;
	logic           last_way;

	cht_hash #(
		.BUCKETS (BUCKETS),
		.KW      (KW)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.key    (key[KW-1:0]),
		.done   (hash_done),
		.bucket (hash_bucket)
	);

	cht_ram #(
		.WIDTH (WAYS),
		.DEPTH (BUCKETS)
	) u_valid_ram (
		.clk   (clk),
		.we    (vram_we),
		.waddr (vram_waddr),
		.wdata (vram_wdata),
		.re    (vram_re),
		.raddr (bucket_q),
		.rdata (vram_rdata)
	);

	cht_ram #(
		.WIDTH (EW),
		.DEPTH (SLOTS)
	) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata ({key_q, value_q}),
		.re    (ent_re),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	assign in_stall = state_q != S_IDLE;
	assign accept   = in_valid && !in_stall;
	assign fin_go   = state_q == S_FIN && (!out_valid_q || !out_stall);

	assign rd_key   = ent_rdata[EW-1:VW];
	assign rd_val   = ent_rdata[VW-1:0];
	assign way_live = vram_rdata[way_s1];
	assign way_hit  = rd_s1 && way_live && rd_key == key_q;
	assign last_way = way_s1 == WW'(WAYS - 1);

	assign vram_re   = state_q == S_WALK;
	assign ent_re    = state_q == S_WALK && rd_way_q < WCW'(WAYS);
	assign ent_raddr = base_q + AW'(rd_way_q);
	assign ent_waddr = base_q + AW'(free_way_q);

	always_comb begin
		ins_ok     = act_q == ACT_INSERT && !hit_q && free_found_q;
		del_ok     = act_q == ACT_DELETE && hit_q;
		fin_rv     = '0;
		fin_status = ST_NOTFOUND;
		case (act_q)
			ACT_INSERT: begin
				if (hit_q) begin
					fin_status = ST_DUP;
				end else if (free_found_q) begin
					fin_status = ST_OK;
				end else begin
					fin_status = ST_FULL;
				end
			end
			default: begin
				// delete, search and the unused code all report the stored value
				if (hit_q) begin
					fin_status = ST_OK;
					fin_rv     = hit_val_q;
				end
			end
		endcase

		ent_we     = fin_go && ins_ok;
		vram_we    = 1'b0;
		vram_waddr = bucket_q;
		vram_wdata = vword_q;
		if (state_q == S_CLR) begin
			vram_we    = 1'b1;
			vram_waddr = clr_q;
			vram_wdata = '0;
		end else if (fin_go && ins_ok) begin
			vram_we    = 1'b1;
			vram_wdata = vword_q | (WAYS'(1) << free_way_q);
		end else if (fin_go && del_ok) begin
			vram_we    = 1'b1;
			vram_wdata = vword_q & ~(WAYS'(1) << hit_way_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_q        <= '0;
			rd_way_q     <= '0;
			rd_s1        <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BW'(BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					rd_way_q     <= '0;
					rd_s1        <= 1'b0;
					hit_q        <= 1'b0;
					free_found_q <= 1'b0;
					if (hash_done) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					rd_s1 <= ent_re;
					if (ent_re) begin
						rd_way_q <= rd_way_q + 1'b1;
					end
					if (way_hit) begin
						hit_q <= 1'b1;
					end
					// lowest free way wins for an insert
					if (rd_s1 && !way_live && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					if (rd_s1 && last_way) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= action;
			key_q   <= key[KW-1:0];
			value_q <= value[VW-1:0];
		end
		if (state_q == S_HASH && hash_done) begin
			bucket_q <= hash_bucket;
			base_q   <= AW'(hash_bucket * WAYS);
		end
		if (ent_re) begin
			way_s1 <= WW'(rd_way_q);
		end
		if (way_hit) begin
			hit_way_q <= way_s1;
			hit_val_q <= rd_val;
		end
		if (rd_s1 && !way_live && !free_found_q) begin
			free_way_q <= way_s1;
		end
		if (rd_s1 && last_way) begin
			vword_q <= vram_rdata;
		end
		if (fin_go) begin
			status_q <= fin_status;
			rv_q     <= fin_rv;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_value = FIELD_W'(rv_q);

`ifndef ASSERT_OFF
	// an entry is written only by an insert of a new key into a bucket with room
	a_entry_write: assert property (@(posedge clk) disable iff (!arst_n)
		ent_we |-> (act_q == ACT_INSERT && !hit_q && free_found_q && state_q == S_FIN))
		else $error("entry write outside a successful insert");

	// a hit way is never also reported as free
	a_hit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && hit_q && free_found_q) |-> hit_way_q != free_way_q)
		else $error("hit way marked free");

	// finishing an item leaves a result waiting and the block ready
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> (out_valid_q && state_q == S_IDLE))
		else $error("finished item left no result");
`endif

endmodule

>>> bench/tb.sv
// testbench for the chained hash key-value table: predictor, queued driver, checking monitor
`timescale 1ns / 1ps

module tb;
	import cht_pkg::*;

	localparam int NB = BUCKETS_DEF;
	localparam int NW = WAYS_DEF;
	localparam int SLOTS = NB * NW;
	localparam action_t ACT_UNUSED = 2'd3;
	localparam int RAND_ITEMS = 630;
	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_CYCLES = 500;

	typedef struct {
		action_t            act;
		logic [FIELD_W-1:0] k;
		logic [FIELD_W-1:0] v;
		bit                 drain;
	} table_req_t;

	typedef struct {
		status_t            st;
		logic [FIELD_W-1:0] val;
	} table_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	action_t action = ACT_SEARCH;
	logic [FIELD_W-1:0] key = '0;
	logic [FIELD_W-1:0] value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	status_t status;
	logic [FIELD_W-1:0] result_value;

	// shadow copy of the table contents
	bit                 tbl_valid [SLOTS];
	logic [FIELD_W-1:0] tbl_key [SLOTS];
	logic [FIELD_W-1:0] tbl_val [SLOTS];

	table_req_t   item_queue [$];
	table_reply_t reply_fifo [$];
	logic [FIELD_W-1:0] key_pool [24];

	int unsigned accepted_cnt = 0;
	int unsigned done_cnt = 0;
	int unsigned fail_cnt = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned stall_mode = 0;
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	bit hold_done = 1'b0;
	int unsigned idle_cycles = 0;

	chained_hash_key_value_table_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.key          (key),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.result_value (result_value)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// search, insert or delete on the shadow table, returning the reply
	function automatic table_reply_t apply_table_action(action_t act, logic [FIELD_W-1:0] k,
			logic [FIELD_W-1:0] v);
		table_reply_t r;
		int base;
		int hit;
		int s;
		base = int'(k % NB) * NW;
		hit = -1;
		r.st = ST_NOTFOUND;
		r.val = '0;
		for (int w = 0; w < NW; w++) begin
			if (hit < 0 && tbl_valid[base + w] && tbl_key[base + w] == k)
				hit = base + w;
		end
		if (act == ACT_INSERT) begin
			if (hit >= 0) begin
				r.st = ST_DUP;
			end else begin
				r.st = ST_FULL;
				s = -1;
				for (int w = 0; w < NW; w++) begin
					if (s < 0 && !tbl_valid[base + w])
						s = base + w;
				end
				if (s >= 0) begin
					tbl_valid[s] = 1'b1;
					tbl_key[s] = k;
					tbl_val[s] = v;
					r.st = ST_OK;
				end
			end
		end else if (hit >= 0) begin
			r.st = ST_OK;
			r.val = tbl_val[hit];
			if (act == ACT_DELETE)
				tbl_valid[hit] = 1'b0;
		end
		return r;
	endfunction

	task automatic queue_item(action_t act, logic [FIELD_W-1:0] k, logic [FIELD_W-1:0] v,
			bit drain = 1'b0);
		table_req_t t;
		t.act = act;
		t.k = k;
		t.v = v;
		t.drain = drain;
		item_queue.push_back(t);
	endtask

	function automatic logic [FIELD_W-1:0] pool_key(int j);
		logic [3:0] bkt;
		logic [31:0] r;
		// most keys crowd into a few buckets so that chains fill up
		bkt = (j < 16) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, NB - 1));
		r = $urandom;
		return {r[FIELD_W-1:4], bkt};
	endfunction

	initial begin
		int pick;
		action_t act;
		logic [FIELD_W-1:0] k;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_key[i] = '0;
			tbl_val[i] = '0;
		end

		// directed: empty table, duplicates, a full bucket, way reuse, unused code
		queue_item(ACT_SEARCH, 32'h0000_0000, 32'h1234_5678);
		queue_item(ACT_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
		queue_item(ACT_INSERT, 32'h0000_0000, 32'h0000_0001);
		queue_item(ACT_SEARCH, 32'h0000_0000, 32'h0000_0000);
		queue_item(ACT_INSERT, 32'h0000_0010, 32'h5555_5555);
		queue_item(ACT_INSERT, 32'h0000_0020, 32'hAAAA_AAAA);
		queue_item(ACT_INSERT, 32'h0000_0030, 32'h0F0F_0F0F);
		queue_item(ACT_INSERT, 32'hFFFF_FFF0, 32'h1111_1111);
		queue_item(ACT_DELETE, 32'h0000_0020, 32'hFFFF_FFFF);
		queue_item(ACT_DELETE, 32'h0000_0020, 32'h0000_0000);
		queue_item(ACT_INSERT, 32'hFFFF_FFF0, 32'h0000_0000);
		queue_item(ACT_INSERT, 32'h0000_0040, 32'h7777_7777);
		queue_item(ACT_UNUSED, 32'h0000_0010, 32'hFFFF_FFFF);
		queue_item(ACT_SEARCH, 32'hFFFF_FFF0, 32'h0000_0000);
		queue_item(ACT_INSERT, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
		queue_item(ACT_SEARCH, 32'hFFFF_FFFF, 32'h5555_5555);
		queue_item(ACT_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
		queue_item(ACT_UNUSED, 32'hFFFF_FFFF, 32'h0000_0000);
		queue_item(ACT_DELETE, 32'h0000_0000, 32'h0000_0000);
		queue_item(ACT_SEARCH, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % 200 == 0) begin
				for (int j = 0; j < 24; j++)
					key_pool[j] = pool_key(j);
			end
			k = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 23)] : $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 40)
				act = ACT_INSERT;
			else if (pick < 70)
				act = ACT_SEARCH;
			else if (pick < 95)
				act = ACT_DELETE;
			else
				act = ACT_UNUSED;
			queue_item(act, k, $urandom, i == 150 || i == 420);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (item_queue.size() != 0 || in_valid || done_cnt != accepted_cnt)
			@(negedge clk);
		repeat (30) @(negedge clk);
		if (reply_fifo.size() != 0) begin
			$error("%0d expected replies never arrived", reply_fifo.size());
			fail_cnt++;
		end
		if (fail_cnt == 0)
			$display("chained_hash_key_value_table_unit: match");
		else
			$display("chained_hash_key_value_table_unit: mismatch");
		$finish;
	end

	// request driver: bursts and gaps, payload held while stalled
	always @(posedge clk or negedge arst_n) begin
		table_req_t nxt;
		bit fire;
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= ACT_SEARCH;
			key <= '0;
			value <= '0;
			burst_left <= $urandom_range(1, 24);
			gap_left <= 0;
		end else begin
			fire = in_valid && !in_stall;
			if (fire) begin
				reply_fifo.push_back(apply_table_action(action, key, value));
				accepted_cnt <= accepted_cnt + 1;
			end
			if (in_valid && !fire) begin
				// stalled transfer keeps its payload
			end else if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (item_queue.size() != 0 &&
					(!item_queue[0].drain || done_cnt == accepted_cnt + fire)) begin
				nxt = item_queue.pop_front();
				in_valid <= 1'b1;
				action <= nxt.act;
				key <= nxt.k;
				value <= nxt.v;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result stall pattern, with one long hold-off once traffic is flowing
	always @(posedge clk or negedge arst_n) begin
		bit nxt_stall;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode <= 0;
			stall_left <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			nxt_stall = 1'b0;
			if (hold_left != 0) begin
				nxt_stall = 1'b1;
				hold_left <= hold_left - 1;
			end else if (!hold_done && done_cnt >= 200) begin
				nxt_stall = 1'b1;
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else begin
				case (stall_mode)
					0: nxt_stall = 1'b0;
					1: nxt_stall = 1'($urandom_range(0, 1));
					2: nxt_stall = ($urandom_range(0, 3) != 0);
					default: nxt_stall = (stall_left % 3 == 0);
				endcase
				if (stall_left == 0) begin
					stall_mode <= $urandom_range(0, 3);
					stall_left <= $urandom_range(16, 96);
				end else begin
					stall_left <= stall_left - 1;
				end
			end
			out_stall <= nxt_stall;
		end
	end

	// reply checker
	always @(posedge clk) begin
		table_reply_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			done_cnt <= done_cnt + 1;
			if (reply_fifo.size() == 0) begin
				$error("reply with no request outstanding: status %0d value %h",
					status, result_value);
				fail_cnt++;
			end else begin
				exp_r = reply_fifo.pop_front();
				if (status !== exp_r.st) begin
					$error("status: expected %0d, got %0d", exp_r.st, status);
					fail_cnt++;
				end
				if (result_value !== exp_r.val) begin
					$error("result_value: expected %h, got %h", exp_r.val, result_value);
					fail_cnt++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("chained_hash_key_value_table_unit: mismatch");
				$finish;
			end
		end
	end

endmodule
